// ----- rtl/sbf_pkg.sv -----
package sbf_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int RAD_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RING       = 15;
    localparam int SLOT_W     = 4;
    localparam int HSUM_W     = 12;
    localparam int ACC_W      = 16;
    localparam int NUM_W      = 18;
    localparam int DEN_W      = 9;
    localparam int RECIP_W    = 32;
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam int LINE_DEPTH = RING * MAX_WIDTH;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HSUM  = 6'b000010,
        ST_VRD   = 6'b000100,
        ST_VLAST = 6'b001000,
        ST_DIV1  = 6'b010000,
        ST_DIV2  = 6'b100000
    } state_t;

    typedef struct packed {
        logic               any;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } range_t;

    // v mod 15 by reciprocal multiply, one correction step
    function automatic logic [SLOT_W-1:0] mod_ring(input logic [COORD_W-1:0] v);
        logic [25:0] prod;
        logic [9:0]  q;
        logic [13:0] qm;
        logic [13:0] rem;
        prod = 26'(v) * 26'd4369;
        q    = prod[25:16];
        qm   = (14'(q) << 4) - 14'(q);
        rem  = 14'(v) - qm;
        if (rem >= 14'd15)
            rem = rem - 14'd15;
        return rem[SLOT_W-1:0];
    endfunction

    // clamp a signed position to [0, lim]
    function automatic logic [COORD_W-1:0] clamp_pos(input logic signed [12:0] s,
                                                    input logic [COORD_W-1:0] lim);
        logic [COORD_W-1:0] res;
        if (s < 13'sd0)
            res = '0;
        else if (s > $signed({3'b000, lim}))
            res = lim;
        else
            res = s[COORD_W-1:0];
        return res;
    endfunction

    // coordinates whose window completes when position c arrives
    function automatic range_t ready_range(input logic [COORD_W-1:0] c,
                                           input logic [DIM_W-1:0]   n,
                                           input logic [RAD_W-1:0]   r);
        range_t             rr;
        logic [DIM_W-1:0]   last;
        last = n - 11'd1;
        if ({1'b0, c} == last) begin
            rr.any = 1'b1;
            rr.hi  = last[COORD_W-1:0];
            rr.lo  = (last >= 11'(r)) ? 10'(last - 11'(r)) : '0;
        end else if (c >= 10'(r)) begin
            rr.any = 1'b1;
            rr.lo  = c - 10'(r);
            rr.hi  = c - 10'(r);
        end else begin
            rr.any = 1'b0;
            rr.lo  = '0;
            rr.hi  = '0;
        end
        return rr;
    endfunction

    function automatic logic [DEN_W-1:0] window_area(input logic [RAD_W-1:0] r);
        logic [DEN_W-1:0] a;
        case (r)
            3'd0:    a = 9'd1;
            3'd1:    a = 9'd9;
            3'd2:    a = 9'd25;
            3'd3:    a = 9'd49;
            3'd4:    a = 9'd81;
            3'd5:    a = 9'd121;
            3'd6:    a = 9'd169;
            default: a = 9'd225;
        endcase
        return a;
    endfunction

    // floor(2^32 / (2 * area))
    function automatic logic [RECIP_W-1:0] area_recip(input logic [RAD_W-1:0] r);
        logic [RECIP_W-1:0] v;
        case (r)
            3'd0:    v = 32'd2147483648;
            3'd1:    v = 32'd238609294;
            3'd2:    v = 32'd85899345;
            3'd3:    v = 32'd43826196;
            3'd4:    v = 32'd26512143;
            3'd5:    v = 32'd17747798;
            3'd6:    v = 32'd12707003;
            default: v = 32'd9544371;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/sbf_if.sv -----
interface sbf_pix_if;
    import sbf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sbf_res_if;
    import sbf_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [PIX_W-1:0]   filtered_value;
    logic               last_of_run;
    modport source (output valid, output out_x, output out_y, output filtered_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_x, input out_y, input filtered_value,
                    input last_of_run, output ready);
endinterface

interface sbf_cfg_if;
    import sbf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/separable_box_filter_top.sv -----
// Channel   Dir  Payload                                      Transaction when
// pixels    in   pixel                                        valid & ready
// results   out  out_x, out_y, filtered_value, last_of_run    valid & ready
// cfg       in   index (0 radius, 1 width, 2 height), data    valid & ready
//
// One pixel at a time. A pixel is stored, then each horizontal sum that it completes
// (1 normally, up to r+1 at row end) is summed over 2r+1 taps and written; each result
// then sums 2r+1 rows via the single line-store read port and is divided; stalls hold it.
// Reset is asynchronous, active low; the line store needs no clearing pass.
// Cfg ready is high only while the sequencer is idle; pixel ready likewise, and
// is held low while a cfg transaction is offered so that the write goes first.
module separable_box_filter_top (
    input logic     clk,
    input logic     rst_n,
    sbf_pix_if.sink pixels,
    sbf_res_if.source results,
    sbf_cfg_if.sink cfg
);
    import sbf_pkg::*;

    state_t               state_reg, state_next;
    logic [RAD_W-1:0]     radius_reg;
    logic [DIM_W-1:0]     width_reg, height_reg;
    logic [COORD_W-1:0]   cx_reg, cy_reg;
    logic [PIX_W-1:0]     rw_reg [RING];
    logic [SLOT_W-1:0]    slot_reg;
    logic [COORD_W-1:0]   xlo_reg, xhi_reg, yhi_reg;
    logic                 yany_reg;
    logic [COORD_W-1:0]   hx_reg, vx_reg, vy_reg;
    logic [3:0]           k_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic                 rd_pend_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 out_valid_reg;
    logic [COORD_W-1:0]   out_x_reg, out_y_reg;
    logic [PIX_W-1:0]     out_val_reg;
    logic                 out_last_reg;

    // effective frame size
    logic [DIM_W-1:0]     w_eff, h_eff;
    logic [COORD_W-1:0]   w_last, h_last;
    logic [3:0]           k_last;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 11'd1;
        else if (width_reg > 11'(MAX_WIDTH))
            w_eff = 11'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = 11'd1;
        else if (height_reg > 11'(MAX_HEIGHT))
            h_eff = 11'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        w_last = 10'(w_eff - 11'd1);
        h_last = 10'(h_eff - 11'd1);
        k_last = {radius_reg, 1'b0};
    end

    // position of the arriving pixel, with frame restart
    logic               restart;
    logic [COORD_W-1:0] cx, cy;
    range_t             xr, yr;
    logic               in_fire, cfg_fire, out_free;

    assign restart  = ({1'b0, cx_reg} >= w_eff) || ({1'b0, cy_reg} >= h_eff);
    assign cx       = restart ? '0 : cx_reg;
    assign cy       = restart ? '0 : cy_reg;
    assign xr       = ready_range(cx, w_eff, radius_reg);
    assign yr       = ready_range(cy, h_eff, radius_reg);
    assign in_fire  = pixels.valid && pixels.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign pixels.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg.ready    = (state_reg == ST_IDLE);

    // horizontal tap
    logic [COORD_W-1:0] hp;
    logic [PIX_W-1:0]   hpix;
    logic [HSUM_W-1:0]  hsum;

    assign hp   = clamp_pos(13'(hx_reg) - 13'(radius_reg) + 13'(k_reg), w_last);
    assign hpix = rw_reg[mod_ring(hp)];
    assign hsum = acc_reg[HSUM_W-1:0] + HSUM_W'(hpix);

    // vertical tap
    logic [COORD_W-1:0]      vrow;
    logic [SLOT_W+COORD_W-1:0] raddr, waddr;
    logic [HSUM_W-1:0]       rdata;
    logic                    we;

    assign vrow  = clamp_pos(13'(vy_reg) - 13'(radius_reg) + 13'(k_reg), h_last);
    assign raddr = {mod_ring(vrow), vx_reg};
    assign waddr = {slot_reg, hx_reg};
    assign we    = (state_reg == ST_HSUM) && (k_reg == k_last);

    sbf_ram #(
        .WIDTH (HSUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (hsum),
        .raddr (raddr),
        .rdata (rdata)
    );

    // rounding divide by window area
    logic [DEN_W-1:0]  area;
    logic [NUM_W-1:0]  num, q0, chk;
    logic [26:0]       qd;
    logic [NUM_W-1:0]  quot;
    logic [DEN_W:0]    den;

    always_comb
    begin
        area = window_area(radius_reg);
        den  = {area, 1'b0};
        num  = {1'b0, acc_reg, 1'b0} + NUM_W'(area);
        q0   = prod_reg[PROD_W-1:RECIP_W];
        qd   = 27'(q0) * 27'(den);
        chk  = num - qd[NUM_W-1:0];
        quot = (chk >= NUM_W'(den)) ? q0 + 18'd1 : q0;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && xr.any)
                    state_next = ST_HSUM;
            ST_HSUM:
                if (k_reg == k_last && hx_reg == xhi_reg)
                    state_next = yany_reg ? ST_VRD : ST_IDLE;
            ST_VRD:
                if (k_reg == k_last)
                    state_next = ST_VLAST;
            ST_VLAST:
                state_next = ST_DIV1;
            ST_DIV1:
                state_next = ST_DIV2;
            ST_DIV2:
                if (out_free)
                    state_next = (vx_reg == xhi_reg && vy_reg == yhi_reg) ? ST_IDLE : ST_VRD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= 3'd1;
            width_reg     <= 11'(MAX_WIDTH);
            height_reg    <= 11'(MAX_HEIGHT);
            cx_reg        <= '0;
            cy_reg        <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    REG_RADIUS:
                    begin
                        radius_reg <= cfg.data[RAD_W-1:0];
                        cx_reg     <= '0;
                        cy_reg     <= '0;
                    end
                    REG_WIDTH:
                    begin
                        width_reg <= cfg.data;
                        cx_reg    <= '0;
                        cy_reg    <= '0;
                    end
                    REG_HEIGHT:
                    begin
                        height_reg <= cfg.data;
                        cx_reg     <= '0;
                        cy_reg     <= '0;
                    end
                    default:
                        ;
                endcase
            end
            else if (in_fire)
            begin
                if ({1'b0, cx} + 11'd1 >= w_eff)
                begin
                    cx_reg <= '0;
                    cy_reg <= ({1'b0, cy} + 11'd1 >= h_eff) ? '0 : cy + 10'd1;
                end
                else
                    cx_reg <= cx + 10'd1;
            end
            rd_pend_reg <= (state_reg == ST_VRD);
            if (state_reg == ST_DIV2 && out_free)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    rw_reg[mod_ring(cx)] <= pixels.pixel;
                    slot_reg <= mod_ring(cy);
                    xlo_reg  <= xr.lo;
                    xhi_reg  <= xr.hi;
                    yhi_reg  <= yr.hi;
                    yany_reg <= yr.any;
                    hx_reg   <= xr.lo;
                    vx_reg   <= xr.lo;
                    vy_reg   <= yr.lo;
                    k_reg    <= '0;
                    acc_reg  <= '0;
                end
            ST_HSUM:
                if (k_reg == k_last)
                begin
                    k_reg   <= '0;
                    acc_reg <= '0;
                    hx_reg  <= hx_reg + 10'd1;
                end
                else
                begin
                    k_reg   <= k_reg + 4'd1;
                    acc_reg <= ACC_W'(hsum);
                end
            ST_VRD:
            begin
                acc_reg <= acc_reg + (rd_pend_reg ? ACC_W'(rdata) : '0);
                k_reg   <= (k_reg == k_last) ? '0 : k_reg + 4'd1;
            end
            ST_VLAST:
                acc_reg <= acc_reg + ACC_W'(rdata);
            ST_DIV1:
                prod_reg <= PROD_W'(num) * PROD_W'(area_recip(radius_reg));
            ST_DIV2:
                if (out_free)
                begin
                    out_x_reg    <= vx_reg;
                    out_y_reg    <= vy_reg;
                    out_val_reg  <= quot[PIX_W-1:0];
                    out_last_reg <= (vx_reg == xhi_reg) && (vy_reg == yhi_reg);
                    acc_reg      <= '0;
                    if (vx_reg == xhi_reg)
                    begin
                        vx_reg <= xlo_reg;
                        vy_reg <= vy_reg + 10'd1;
                    end
                    else
                        vx_reg <= vx_reg + 10'd1;
                end
            default:
                ;
        endcase
    end

    assign results.valid          = out_valid_reg;
    assign results.out_x          = out_x_reg;
    assign results.out_y          = out_y_reg;
    assign results.filtered_value = out_val_reg;
    assign results.last_of_run    = out_last_reg;

endmodule

// ----- rtl/sbf_ram.sv -----
module sbf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ----- tb/tb_separable_box_filter_top.sv -----
module tb_separable_box_filter_top;
    import sbf_pkg::*;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 200;
    localparam int ITEM_TARGET = 430;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   value;
        logic               last;
    } mean_t;

    logic clk;
    logic rst_n;

    sbf_pix_if pixels ();
    sbf_res_if results ();
    sbf_cfg_if cfg ();

    separable_box_filter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .results (results),
        .cfg     (cfg)
    );

    // filter state as seen by the predictor
    logic [RAD_W-1:0]   cur_radius;
    logic [DIM_W-1:0]   cur_width;
    logic [DIM_W-1:0]   cur_height;
    int                 col_pos;
    int                 row_pos;
    logic [PIX_W-1:0]   line_pixels [RING];
    logic [HSUM_W-1:0]  hsum_rows [RING][MAX_WIDTH];

    mean_t              means_due [$];
    logic [PIX_W-1:0]   pixel_queue [$];
    int                 error_count = 0;
    int                 items_sent = 0;
    bit                 calm = 0;
    bit                 pix_taken = 0;
    bit                 res_taken = 0;
    int                 pix_wait = 0;
    int                 res_wait = 0;
    int                 quiet_cycles = 0;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // span of coordinates whose window is complete once position c arrives
    function automatic void done_span(input int c, input int n, input int r,
                                      output int lo, output int hi);
        if (c == n - 1) begin
            lo = clamp_int(n - 1 - r, 0, n - 1);
            hi = n - 1;
        end else if (c >= r) begin
            lo = c - r;
            hi = c - r;
        end else begin
            lo = 1;
            hi = 0;
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] d);
        if (idx == REG_RADIUS) cur_radius = d[RAD_W-1:0];
        else if (idx == REG_WIDTH) cur_width = d;
        else if (idx == REG_HEIGHT) cur_height = d;
        else return;
        col_pos = 0;
        row_pos = 0;
    endfunction

    // box means released by one incoming pixel
    function automatic void predict_means(input logic [PIX_W-1:0] px);
        int    r, w, h, area, xlo, xhi, ylo, yhi, s, vs;
        mean_t batch [$];
        mean_t m;
        r = cur_radius;
        w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH ? MAX_WIDTH : cur_width);
        h = (cur_height == 0) ? 1 : (cur_height > MAX_HEIGHT ? MAX_HEIGHT : cur_height);
        area = (2 * r + 1) * (2 * r + 1);
        if (col_pos >= w || row_pos >= h) begin
            col_pos = 0;
            row_pos = 0;
        end
        line_pixels[col_pos % RING] = px;
        done_span(col_pos, w, r, xlo, xhi);
        for (int x = xlo; x <= xhi; x++) begin
            s = 0;
            for (int d = -r; d <= r; d++)
                s += line_pixels[clamp_int(x + d, 0, w - 1) % RING];
            hsum_rows[row_pos % RING][x] = HSUM_W'(s);
        end
        done_span(row_pos, h, r, ylo, yhi);
        for (int y = ylo; y <= yhi; y++)
            for (int x = xlo; x <= xhi; x++) begin
                vs = 0;
                for (int d = -r; d <= r; d++)
                    vs += hsum_rows[clamp_int(y + d, 0, h - 1) % RING][x];
                m.x = COORD_W'(x);
                m.y = COORD_W'(y);
                m.value = PIX_W'((2 * vs + area) / (2 * area));
                m.last = 1'b0;
                batch.push_back(m);
            end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) means_due.push_back(batch[i]);
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // pixel transactions and result checks at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (pixels.valid && pixels.ready) begin
                predict_means(pixels.pixel);
                pix_taken <= 1'b1;
            end
            if (results.valid && results.ready) begin
                res_taken <= 1'b1;
                if (means_due.size() == 0) begin
                    $error("unexpected result x=%0d y=%0d", results.out_x, results.out_y);
                    error_count++;
                end else begin
                    mean_t e;
                    e = means_due.pop_front();
                    if (results.out_x !== e.x) begin
                        $error("out_x expected %0d got %0d", e.x, results.out_x);
                        error_count++;
                    end
                    if (results.out_y !== e.y) begin
                        $error("out_y expected %0d got %0d", e.y, results.out_y);
                        error_count++;
                    end
                    if (results.filtered_value !== e.value) begin
                        $error("filtered_value expected %0d got %0d", e.value,
                               results.filtered_value);
                        error_count++;
                    end
                    if (results.last_of_run !== e.last) begin
                        $error("last_of_run expected %0d got %0d", e.last,
                               results.last_of_run);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((pixels.valid && pixels.ready) || (results.valid && results.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // pixel driver with random gaps
    always @(negedge clk)
    begin
        if (!pixels.valid || pix_taken) begin
            pix_taken <= 1'b0;
            if (pix_wait > 0) begin
                pix_wait--;
                pixels.valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                pixels.pixel <= pixel_queue.pop_front();
                pixels.valid <= 1'b1;
                pix_wait = calm ? 0 : $urandom_range(0, 3);
            end else begin
                pixels.valid <= 1'b0;
            end
        end
    end

    // result sink with random stalls
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (res_taken) begin
                res_taken <= 1'b0;
                res_wait = calm ? 0 : $urandom_range(0, 3);
            end
            if (res_wait > 0) begin
                res_wait--;
                results.ready <= 1'b0;
            end else begin
                results.ready <= 1'b1;
            end
        end
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do @(posedge clk); while (!cfg.ready);
        apply_register(idx, d);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // block has drained: nothing queued, nothing due, then settle
    task automatic wait_idle();
        while (pixel_queue.size() > 0 || pixels.valid || means_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_frame(input int r, input int w, input int h, input int count);
        wait_idle();
        write_register(REG_RADIUS, CFG_DATA_W'(r));
        write_register(REG_WIDTH, CFG_DATA_W'(w));
        write_register(REG_HEIGHT, CFG_DATA_W'(h));
        calm = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0: pixel_queue.push_back(8'd0);
                1: pixel_queue.push_back(8'd255);
                default: pixel_queue.push_back(PIX_W'($urandom_range(0, 255)));
            endcase
        end
        items_sent += count;
    endtask

    // stimulus
    initial
    begin
        int w, h, n;
        rst_n = 1'b0;
        pixels.valid = 1'b0;
        pixels.pixel = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_RADIUS;
        cfg.data = '0;
        cur_radius = 3'd1;
        cur_width = 11'd1024;
        cur_height = 11'd1024;
        col_pos = 0;
        row_pos = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, a few pixels of the first row
        pixel_queue.push_back(8'd0);
        pixel_queue.push_back(8'd255);
        for (int i = 0; i < 4; i++) pixel_queue.push_back(PIX_W'($urandom_range(0, 255)));
        items_sent = 6;

        // directed corners: radius extremes, saturated and zero sizes
        run_frame(0, 3, 2, 6);
        run_frame(7, 3, 2, 6);
        run_frame(7, 1024, 1, 20);
        run_frame(2, 0, 2047, 4);
        run_frame(3, 2047, 0, 12);
        run_frame(5, 1, 1, 3);
        // a write to the unused index changes nothing
        wait_idle();
        write_register(REG_SPARE, 11'h7FF);
        pixel_queue.push_back(PIX_W'($urandom_range(0, 255)));
        items_sent++;

        // random frames, mostly small, some ended early, some run on into a new frame
        while (items_sent < ITEM_TARGET) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            n = w * h;
            case ($urandom_range(0, 3))
                0: n = $urandom_range(1, n);
                1: n = n + $urandom_range(1, n);
                default: ;
            endcase
            if (n > ITEM_TARGET - items_sent)
                n = ITEM_TARGET - items_sent;
            run_frame($urandom_range(0, 7), w, h, n);
        end

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
